>>> src/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and codes for the delta-list timeout queue
// Beat layouts, action, result-kind and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dltq_pkg;

  localparam int unsigned ID_W        = 4;
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned TIMEOUT_W   = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned MAX_EXPIRE  = 16;
  localparam int unsigned CNT_W       = 4;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IDLE    = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO_TO    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ALREADY_Q  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_QUEUED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [STAT_W-1:0] status;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

>>> src/dltq_ram.sv
// ----------------------------------------------------------------------------
// dltq_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered (read-first).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dltq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/delta_list_timeout_queue.sv
// ----------------------------------------------------------------------------
// delta_list_timeout_queue: timeout queue kept as a delta list
// Slots sit in a doubly linked list ordered by expiry, each holding its delay
// relative to its predecessor. Insert, remove and tick run on one shared
// read/compare/subtract datapath under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tuser          | tdata (low bit up)                 | tlast
//  ---------+-----+----------------+------------------------------------+------
//  s_axis   | in  | action [1:0]   | entry_id[3:0], timeout_ticks[35:4] | -
//  m_axis   | out | kind [1:0]     | entry_id_out[3:0], status[5:4]     | last
//
//  Insert compares each slot walked, then writes in two steps; a rejected
//  item goes straight to its result. Remove reads, then unlinks the slot.
//  A tick decrements the head and unlinks expired slots (up to 16 per tick).
//  The walk is bound by the registered read of the delta and link RAMs.
//  s_axis_tready is high only between items; an output register holds the
//  final beat, so the next item is taken while that beat waits.
//  A stalled m_axis holds the sequencer on each result beat.
//  Link and delta RAMs need no clearing; queued flags and control regs reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module delta_list_timeout_queue #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned TICK_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // entry_id[3:0], timeout_ticks[35:4], zero fill[39:36]
  input  wire logic [dltq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // action[1:0]
  input  wire logic [dltq_pkg::ACT_W-1:0]          s_axis_tuser,
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // entry_id_out[3:0], status[5:4], zero fill[7:6]
  output      logic [dltq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // kind[1:0]
  output      logic [dltq_pkg::KIND_W-1:0]         m_axis_tuser,
  output      logic                                m_axis_tlast
);

  import dltq_pkg::*;

  localparam int unsigned SLOT_W = $clog2(ENTRIES);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_INS_RD  = 4'd1;
  localparam logic [3:0] ST_INS_CMP = 4'd2;
  localparam logic [3:0] ST_INS_W1  = 4'd3;
  localparam logic [3:0] ST_INS_W2  = 4'd4;
  localparam logic [3:0] ST_UL_RD1  = 4'd5;
  localparam logic [3:0] ST_UL_RD2  = 4'd6;
  localparam logic [3:0] ST_UL_ADD  = 4'd7;
  localparam logic [3:0] ST_TK_RD   = 4'd8;
  localparam logic [3:0] ST_TK_DEC  = 4'd9;
  localparam logic [3:0] ST_EMIT    = 4'd10;

  // input beat fields
  logic [ID_W-1:0]      in_id;
  logic [TIMEOUT_W-1:0] in_timeout;
  logic [SLOT_W-1:0]    in_slot;
  logic                 in_id_ok;
  logic                 in_sat;
  logic [TICK_BITS-1:0] in_delay;

  assign in_id      = s_axis_tdata[ID_W-1:0];
  assign in_timeout = s_axis_tdata[ID_W+TIMEOUT_W-1:ID_W];
  assign in_slot    = SLOT_W'(in_id);
  assign in_id_ok   = int'(in_id) < int'(ENTRIES);
  assign in_sat     = |(in_timeout >> TICK_BITS);
  assign in_delay   = in_sat ? {TICK_BITS{1'b1}} : TICK_BITS'(in_timeout);

  // control state
  logic [3:0]         state_q, state_d;
  logic [SLOT_W-1:0]  head_q, head_d;
  logic [SLOT_W-1:0]  tail_q, tail_d;
  logic               nonempty_q, nonempty_d;
  logic [ENTRIES-1:0] queued_q, queued_d;
  logic               out_valid_q, out_valid_d;

  // working registers
  logic                 tick_q, tick_d;
  logic [ID_W-1:0]      id_q, id_d;
  logic [SLOT_W-1:0]    n_q, n_d;
  logic [TICK_BITS-1:0] delay_q, delay_d;
  logic [SLOT_W-1:0]    cur_q, cur_d;
  logic [SLOT_W-1:0]    pv_q, pv_d;
  logic                 pv_valid_q, pv_valid_d;
  logic                 have_q, have_d;
  logic [TICK_BITS-1:0] cur_delta_q, cur_delta_d;
  logic [SLOT_W-1:0]    nx_q, nx_d;
  logic [TICK_BITS-1:0] dn_q, dn_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  result_t              res_q, res_d;
  result_t              out_q;
  logic                 out_load;

  // RAM ports
  logic                 dram_we, nram_we, pram_we;
  logic [SLOT_W-1:0]    dram_waddr, nram_waddr, pram_waddr;
  logic [SLOT_W-1:0]    dram_raddr, nram_raddr, pram_raddr;
  logic [TICK_BITS-1:0] dram_wdata, dram_rdata;
  logic [SLOT_W-1:0]    nram_wdata, nram_rdata;
  logic [SLOT_W-1:0]    pram_wdata, pram_rdata;

  // datapath helpers
  logic                 is_head, is_tail;
  logic [TICK_BITS-1:0] sum;
  logic                 more;

  assign is_head = (n_q == head_q);
  assign is_tail = (n_q == tail_q);
  assign sum     = dram_rdata + dn_q;
  assign more    = tick_q && (sum == '0) && (cnt_q != CNT_W'(MAX_EXPIRE - 1));

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    nonempty_d  = nonempty_q;
    queued_d    = queued_q;
    tick_d      = tick_q;
    id_d        = id_q;
    n_d         = n_q;
    delay_d     = delay_q;
    cur_d       = cur_q;
    pv_d        = pv_q;
    pv_valid_d  = pv_valid_q;
    have_d      = have_q;
    cur_delta_d = cur_delta_q;
    nx_d        = nx_q;
    dn_d        = dn_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;

    dram_we    = 1'b0;
    dram_waddr = n_q;
    dram_wdata = delay_q;
    dram_raddr = n_q;
    nram_we    = 1'b0;
    nram_waddr = n_q;
    nram_wdata = '0;
    nram_raddr = n_q;
    pram_we    = 1'b0;
    pram_waddr = n_q;
    pram_wdata = pv_q;
    pram_raddr = n_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          id_d       = in_id;
          n_d        = in_slot;
          tick_d     = 1'b0;
          cnt_d      = '0;
          res_d      = '{kind: KIND_DONE, id: in_id, status: STAT_OK, last: 1'b1};
          state_d    = ST_EMIT;
          case (s_axis_tuser)
            ACT_INSERT: begin
              if (in_timeout == '0) begin
                res_d.status = STAT_ZERO_TO;
              end else if (!in_id_ok) begin
                res_d.status = STAT_NOT_QUEUED;
              end else if (queued_q[in_slot]) begin
                res_d.status = STAT_ALREADY_Q;
              end else begin
                delay_d    = in_delay;
                cur_d      = head_q;
                have_d     = nonempty_q;
                pv_d       = '0;
                pv_valid_d = 1'b0;
                state_d    = nonempty_q ? ST_INS_RD : ST_INS_W1;
              end
            end
            ACT_REMOVE: begin
              if (!in_id_ok || !queued_q[in_slot]) begin
                res_d.status = STAT_NOT_QUEUED;
              end else begin
                state_d = ST_UL_RD1;
              end
            end
            ACT_TICK: begin
              res_d = '{kind: KIND_IDLE, id: '0, status: STAT_OK, last: 1'b1};
              if (nonempty_q) begin
                tick_d  = 1'b1;
                state_d = ST_TK_RD;
              end
            end
            default: begin
              res_d = '{kind: KIND_IDLE, id: '0, status: STAT_OK, last: 1'b1};
            end
          endcase
        end
      end

      ST_INS_RD: begin
        dram_raddr = cur_q;
        nram_raddr = cur_q;
        state_d    = ST_INS_CMP;
      end

      ST_INS_CMP: begin
        // pass over slots whose delta is strictly smaller than what remains
        if (dram_rdata < delay_q) begin
          delay_d    = delay_q - dram_rdata;
          pv_d       = cur_q;
          pv_valid_d = 1'b1;
          if (cur_q == tail_q) begin
            have_d  = 1'b0;
            state_d = ST_INS_W1;
          end else begin
            cur_d   = nram_rdata;
            state_d = ST_INS_RD;
          end
        end else begin
          cur_delta_d = dram_rdata;
          state_d     = ST_INS_W1;
        end
      end

      ST_INS_W1: begin
        dram_we    = 1'b1;
        dram_wdata = delay_q;
        nram_we    = 1'b1;
        nram_wdata = have_q ? cur_q : '0;
        pram_we    = 1'b1;
        pram_wdata = pv_q;
        queued_d[n_q] = 1'b1;
        if (have_q && !pv_valid_q) begin
          head_d = n_q;
        end
        if (!have_q && pv_valid_q) begin
          tail_d = n_q;
        end
        if (!have_q && !pv_valid_q) begin
          head_d     = n_q;
          tail_d     = n_q;
          nonempty_d = 1'b1;
        end
        state_d = ST_INS_W2;
      end

      ST_INS_W2: begin
        if (have_q) begin
          dram_we    = 1'b1;
          dram_waddr = cur_q;
          dram_wdata = cur_delta_q - delay_q;
          pram_we    = 1'b1;
          pram_waddr = cur_q;
          pram_wdata = n_q;
        end
        if (pv_valid_q) begin
          nram_we    = 1'b1;
          nram_waddr = pv_q;
          nram_wdata = n_q;
        end
        state_d = ST_EMIT;
      end

      ST_UL_RD1: begin
        state_d = ST_UL_RD2;
      end

      ST_UL_RD2: begin
        nx_d          = nram_rdata;
        dn_d          = dram_rdata;
        queued_d[n_q] = 1'b0;
        res_d.last    = 1'b1;
        if (tick_q) begin
          res_d.kind = KIND_EXPIRED;
          res_d.id   = ID_W'(n_q);
        end
        if (is_head && is_tail) begin
          nonempty_d = 1'b0;
          state_d    = ST_EMIT;
        end else begin
          if (!is_tail) begin
            pram_we    = 1'b1;
            pram_waddr = nram_rdata;
            pram_wdata = pram_rdata;
            dram_raddr = nram_rdata;
            state_d    = ST_UL_ADD;
          end else begin
            tail_d  = pram_rdata;
            state_d = ST_EMIT;
          end
          if (!is_head) begin
            nram_we    = 1'b1;
            nram_waddr = pram_rdata;
            nram_wdata = nram_rdata;
          end else begin
            head_d = nram_rdata;
          end
        end
      end

      ST_UL_ADD: begin
        // fold the removed delta into the successor
        dram_we    = 1'b1;
        dram_waddr = nx_q;
        dram_wdata = sum;
        res_d.last = !more;
        state_d    = ST_EMIT;
      end

      ST_TK_RD: begin
        dram_raddr = head_q;
        state_d    = ST_TK_DEC;
      end

      ST_TK_DEC: begin
        if (dram_rdata != '0) begin
          dram_we    = 1'b1;
          dram_waddr = head_q;
          dram_wdata = dram_rdata - TICK_BITS'(1);
        end
        if (dram_rdata <= TICK_BITS'(1)) begin
          n_d     = head_q;
          state_d = ST_UL_RD1;
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (res_q.last) begin
            state_d = ST_IDLE;
          end else begin
            // next zero-delta slot at the head
            cnt_d   = cnt_q + CNT_W'(1);
            n_d     = head_q;
            state_d = ST_UL_RD1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      nonempty_q  <= 1'b0;
      queued_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      nonempty_q  <= nonempty_d;
      queued_q    <= queued_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q      <= tick_d;
    id_q        <= id_d;
    n_q         <= n_d;
    delay_q     <= delay_d;
    cur_q       <= cur_d;
    pv_q        <= pv_d;
    pv_valid_q  <= pv_valid_d;
    have_q      <= have_d;
    cur_delta_q <= cur_delta_d;
    nx_q        <= nx_d;
    dn_q        <= dn_d;
    cnt_q       <= cnt_d;
    res_q       <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {{(OUT_TDATA_W - ID_W - STAT_W){1'b0}}, out_q.status, out_q.id};

  dltq_ram #(
    .WIDTH (TICK_BITS),
    .DEPTH (ENTRIES)
  ) u_delta_ram (
    .clk_i   (clk_i),
    .we_i    (dram_we),
    .waddr_i (dram_waddr),
    .wdata_i (dram_wdata),
    .raddr_i (dram_raddr),
    .rdata_o (dram_rdata)
  );

  dltq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (ENTRIES)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nram_we),
    .waddr_i (nram_waddr),
    .wdata_i (nram_wdata),
    .raddr_i (nram_raddr),
    .rdata_o (nram_rdata)
  );

  dltq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (ENTRIES)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pram_we),
    .waddr_i (pram_waddr),
    .wdata_i (pram_wdata),
    .raddr_i (pram_raddr),
    .rdata_o (pram_rdata)
  );

endmodule

`default_nettype wire

>>> src/dltq_check.sv
// ----------------------------------------------------------------------------
// dltq_check: port-level checks for the delta-list timeout queue
// Watches both stream channels and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dltq_check (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [dltq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [dltq_pkg::KIND_W-1:0]      m_axis_tuser,
  input wire logic                             m_axis_tlast
);

  import dltq_pkg::*;

  logic [ID_W-1:0]   out_id;
  logic [STAT_W-1:0] out_status;

  assign out_id     = m_axis_tdata[ID_W-1:0];
  assign out_status = m_axis_tdata[ID_W+STAT_W-1:ID_W];

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // every accepted item keeps the sequencer busy, so s_axis_tready drops in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on back-to-back cycles");

  a_expired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_EXPIRED |-> out_status == STAT_OK)
    else $error("expiry beat with error status");

  a_idle_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_IDLE |->
      m_axis_tlast && out_id == '0 && out_status == STAT_OK)
    else $error("malformed no-expiry beat");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_DONE |-> m_axis_tlast)
    else $error("insert/remove answer without tlast");

endmodule

bind delta_list_timeout_queue dltq_check u_dltq_check (.*);

`default_nettype wire
